// File: hdl/qslerp_pkg.sv
package qslerp_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [33:0] INV_GAIN = 34'd652032874;
    localparam logic [30:0] THETA_MIN = 31'd1073;
    localparam logic [16:0] T_ONE = 17'd65536;

    typedef struct packed {
        logic [3:0][15:0] p;
        logic [3:0][16:0] q;
        logic [16:0]      t;
    } side_t;

    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] a;
        case (i)
            0:  a = 30'd843314857;
            1:  a = 30'd497837829;
            2:  a = 30'd263043837;
            3:  a = 30'd133525159;
            4:  a = 30'd67021687;
            5:  a = 30'd33543516;
            6:  a = 30'd16775851;
            7:  a = 30'd8388437;
            8:  a = 30'd4194283;
            9:  a = 30'd2097149;
            10: a = 30'd1048576;
            11: a = 30'd524288;
            12: a = 30'd262144;
            13: a = 30'd131072;
            14: a = 30'd65536;
            15: a = 30'd32768;
            16: a = 30'd16384;
            17: a = 30'd8192;
            18: a = 30'd4096;
            19: a = 30'd2048;
            20: a = 30'd1024;
            21: a = 30'd512;
            22: a = 30'd256;
            23: a = 30'd128;
            24: a = 30'd64;
            25: a = 30'd32;
            26: a = 30'd16;
            27: a = 30'd8;
            28: a = 30'd4;
            29: a = 30'd2;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/qslerp_dot.sv
module qslerp_dot (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  qslerp_pkg::side_t  in_side,
    output logic               out_valid,
    output logic [30:0]        out_dot,
    output logic [60:0]        out_v,
    output qslerp_pkg::side_t  out_side
);
    import qslerp_pkg::*;

    logic [3:0]         valid_reg;
    side_t              s1_reg, s2_reg, s3_reg, s4_reg;
    side_t              s1_next, s2_next;
    logic signed [31:0] prod_reg [4];
    logic signed [33:0] sum;
    logic [33:0]        mag;
    logic [30:0]        dot_next, dot2_reg, dot3_reg, dot4_reg;
    logic [61:0]        sq_reg;
    logic [60:0]        v_reg;

    always_comb begin
        s1_next = in_side;
        s1_next.t = (in_side.t > T_ONE) ? T_ONE : in_side.t;
    end

    always_comb begin
        sum = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        mag = (sum < 0) ? 34'(-sum) : 34'(sum);
        dot_next = (mag > 34'(ONE_Q30)) ? ONE_Q30 : mag[30:0];
        s2_next = s1_reg;
        for (int i = 0; i < 4; i++) begin
            if (sum < 0) begin
                s2_next.q[i] = 17'(-$signed(s1_reg.q[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= $signed(in_side.p[i]) * $signed(in_side.q[i][15:0]);
            end
            s1_reg   <= s1_next;
            dot2_reg <= dot_next;
            s2_reg   <= s2_next;
            sq_reg   <= 62'(dot2_reg) * 62'(dot2_reg);
            dot3_reg <= dot2_reg;
            s3_reg   <= s2_reg;
            v_reg    <= (61'd1 << 60) - sq_reg[60:0];
            dot4_reg <= dot3_reg;
            s4_reg   <= s3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_dot   = dot4_reg;
    assign out_v     = v_reg;
    assign out_side  = s4_reg;

endmodule

// File: hdl/qslerp_isqrt.sv
module qslerp_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [60:0]      in_v,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [30:0]      out_root,
    output logic [TAG_W-1:0] out_tag
);
    localparam int STEPS = 31;

    logic [60:0]      rem_w [STEPS+1];
    logic [61:0]      res_w [STEPS+1];
    logic [TAG_W-1:0] tag_w [STEPS+1];
    logic [STEPS:0]   valid_w;
    logic [60:0]      rem_reg [STEPS];
    logic [61:0]      res_reg [STEPS];
    logic [TAG_W-1:0] tag_reg [STEPS];
    logic [STEPS-1:0] valid_reg;

    assign rem_w[0]   = in_v;
    assign res_w[0]   = '0;
    assign tag_w[0]   = in_tag;
    assign valid_w[0] = in_valid;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0] trial;
        logic        ge;

        assign trial = res_w[k] + BIT;
        assign ge    = {1'b0, rem_w[k]} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? rem_w[k] - trial[60:0] : rem_w[k];
                res_reg[k] <= ge ? (res_w[k] >> 1) + BIT : res_w[k] >> 1;
                tag_reg[k] <= tag_w[k];
            end
        end

        assign rem_w[k+1]   = rem_reg[k];
        assign res_w[k+1]   = res_reg[k];
        assign tag_w[k+1]   = tag_reg[k];
        assign valid_w[k+1] = valid_reg[k];
    end

    assign out_valid = valid_w[STEPS];
    assign out_root  = res_w[STEPS][30:0];
    assign out_tag   = tag_w[STEPS];

endmodule

// File: hdl/qslerp_cordic.sv
module qslerp_cordic #(
    parameter bit VECTORING = 1'b0,
    parameter int LANES     = 1,
    parameter int TAG_W     = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [LANES-1:0][33:0] x_i,
    input  logic [LANES-1:0][33:0] y_i,
    input  logic [LANES-1:0][31:0] z_i,
    input  logic [TAG_W-1:0]       in_tag,
    output logic                   out_valid,
    output logic [LANES-1:0][30:0] y_o,
    output logic [LANES-1:0][30:0] z_o,
    output logic [TAG_W-1:0]       out_tag
);
    import qslerp_pkg::*;

    logic signed [33:0] x_w [CORDIC_STEPS+1][LANES];
    logic signed [33:0] y_w [CORDIC_STEPS+1][LANES];
    logic signed [31:0] z_w [CORDIC_STEPS+1][LANES];
    logic [TAG_W-1:0]   tag_w [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] valid_w;
    logic signed [33:0] x_reg [CORDIC_STEPS][LANES];
    logic signed [33:0] y_reg [CORDIC_STEPS][LANES];
    logic signed [31:0] z_reg [CORDIC_STEPS][LANES];
    logic [TAG_W-1:0]   tag_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] valid_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_in
        assign x_w[0][l] = $signed(x_i[l]);
        assign y_w[0][l] = $signed(y_i[l]);
        assign z_w[0][l] = $signed(z_i[l]);
    end
    assign tag_w[0]   = in_tag;
    assign valid_w[0] = in_valid;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [31:0] ATAN = $signed(32'(atan_q30(k)));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[k] <= tag_w[k];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [33:0] dx, dy;
            logic               up;

            assign dx = y_w[k][l] >>> k;
            assign dy = x_w[k][l] >>> k;
            assign up = VECTORING ? (y_w[k][l] >= 0) : (z_w[k][l] < 0);

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k][l] <= up ? x_w[k][l] + dx : x_w[k][l] - dx;
                    y_reg[k][l] <= up ? y_w[k][l] - dy : y_w[k][l] + dy;
                    z_reg[k][l] <= up ? z_w[k][l] + ATAN : z_w[k][l] - ATAN;
                end
            end

            assign x_w[k+1][l] = x_reg[k][l];
            assign y_w[k+1][l] = y_reg[k][l];
            assign z_w[k+1][l] = z_reg[k][l];
        end

        assign tag_w[k+1]   = tag_reg[k];
        assign valid_w[k+1] = valid_reg[k];
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (y_w[CORDIC_STEPS][l] < 0) begin
                y_o[l] = '0;
            end else if (y_w[CORDIC_STEPS][l] > $signed({3'b000, ONE_Q30})) begin
                y_o[l] = ONE_Q30;
            end else begin
                y_o[l] = y_w[CORDIC_STEPS][l][30:0];
            end
            if (z_w[CORDIC_STEPS][l] < 0) begin
                z_o[l] = '0;
            end else if (z_w[CORDIC_STEPS][l] > $signed({1'b0, HALF_PI_Q30})) begin
                z_o[l] = HALF_PI_Q30;
            end else begin
                z_o[l] = z_w[CORDIC_STEPS][l][30:0];
            end
        end
    end

    assign out_valid = valid_w[CORDIC_STEPS];
    assign out_tag   = tag_w[CORDIC_STEPS];

endmodule

// File: hdl/qslerp_div.sv
module qslerp_div #(
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [LANES-1:0][30:0] num_i,
    input  logic [30:0]            den_i,
    input  logic [TAG_W-1:0]       in_tag,
    output logic                   out_valid,
    output logic [LANES-1:0][31:0] q_o,
    output logic [TAG_W-1:0]       out_tag
);
    localparam int STEPS = 33;
    localparam logic [32:0] Q_MAX = 33'd1 << 31;

    logic [60:0]      rem_w [STEPS+1][LANES];
    logic [32:0]      q_w   [STEPS+1][LANES];
    logic             ovf_w [STEPS+1][LANES];
    logic [30:0]      den_w [STEPS+1];
    logic [TAG_W-1:0] tag_w [STEPS+1];
    logic [STEPS:0]   valid_w;
    logic [60:0]      rem_reg [STEPS][LANES];
    logic [32:0]      q_reg   [STEPS][LANES];
    logic             ovf_reg [STEPS][LANES];
    logic [30:0]      den_reg [STEPS];
    logic [TAG_W-1:0] tag_reg [STEPS];
    logic [STEPS-1:0] valid_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_in
        assign rem_w[0][l] = {num_i[l], 30'd0};
        assign q_w[0][l]   = '0;
        assign ovf_w[0][l] = 34'(num_i[l]) >= {den_i, 3'b000};
    end
    assign den_w[0]   = den_i;
    assign tag_w[0]   = in_tag;
    assign valid_w[0] = in_valid;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = STEPS - 1 - k;
        logic [63:0] trial;

        assign trial = 64'(den_w[k]) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_w[k];
                tag_reg[k] <= tag_w[k];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic ge;

            assign ge = 64'(rem_w[k][l]) >= trial;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l] <= ge ? rem_w[k][l] - trial[60:0] : rem_w[k][l];
                    q_reg[k][l]   <= ge ? (q_w[k][l] | (33'd1 << B)) : q_w[k][l];
                    ovf_reg[k][l] <= ovf_w[k][l];
                end
            end

            assign rem_w[k+1][l] = rem_reg[k][l];
            assign q_w[k+1][l]   = q_reg[k][l];
            assign ovf_w[k+1][l] = ovf_reg[k][l];
        end

        assign den_w[k+1]   = den_reg[k];
        assign tag_w[k+1]   = tag_reg[k];
        assign valid_w[k+1] = valid_reg[k];
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (ovf_w[STEPS][l] || (q_w[STEPS][l] > Q_MAX)) begin
                q_o[l] = Q_MAX[31:0];
            end else begin
                q_o[l] = q_w[STEPS][l][31:0];
            end
        end
    end

    assign out_valid = valid_w[STEPS];
    assign out_tag   = tag_w[STEPS];

endmodule

// File: hdl/qslerp_blend.sv
module qslerp_blend (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              in_lin,
    input  logic [31:0]       in_m1,
    input  logic [31:0]       in_m2,
    input  qslerp_pkg::side_t in_side,
    output logic              out_valid,
    output logic [3:0][15:0]  out_result
);
    import qslerp_pkg::*;

    logic [2:0]         valid_reg;
    logic [31:0]        w1_reg, w2_reg;
    side_t              s1_reg;
    logic signed [48:0] prod1_reg [4];
    logic signed [49:0] prod2_reg [4];
    logic [3:0][15:0]   result_reg;
    logic [3:0][15:0]   result_next;
    logic signed [50:0] acc [4];
    logic signed [50:0] sh [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            acc[i] = 51'(prod1_reg[i]) + 51'(prod2_reg[i]) + $signed(51'd1 << 29);
            sh[i]  = acc[i] >>> 30;
            if (sh[i] > 51'sd32767) begin
                result_next[i] = 16'h7fff;
            end else if (sh[i] < -51'sd32768) begin
                result_next[i] = 16'h8000;
            end else begin
                result_next[i] = sh[i][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg <= in_lin ? 32'({T_ONE - in_side.t, 14'd0}) : in_m1;
            w2_reg <= in_lin ? 32'({in_side.t, 14'd0}) : in_m2;
            s1_reg <= in_side;
            for (int i = 0; i < 4; i++) begin
                prod1_reg[i] <= $signed({1'b0, w1_reg}) * $signed(s1_reg.p[i]);
                prod2_reg[i] <= $signed({1'b0, w2_reg}) * $signed(s1_reg.q[i]);
            end
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg[2];
    assign out_result = result_reg;

endmodule

// File: hdl/quaternion_slerp_top.sv
// Throughput: one beat per cycle when not stalled; each stage then takes a new item per cycle.
// The whole pipeline advances whenever the output register is empty or being read.
// Reset (aresetn low at a clock edge) clears all valid bits; data registers keep their values.
module quaternion_slerp_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z,
    // fraction, zero fill
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_w, result_x, result_y, result_z
    output logic [63:0]  m_tdata
);
    import qslerp_pkg::*;

    localparam int SIDE_W = $bits(side_t);

    logic                  en;
    side_t                 in_side;
    logic                  dot_valid;
    logic [30:0]           dot_val;
    logic [60:0]           dot_v;
    side_t                 dot_side;
    logic                  sq_valid;
    logic [30:0]           sq_root;
    logic [SIDE_W+30:0]    sq_tag;
    logic                  at_valid;
    logic [0:0][30:0]      at_theta;
    logic [SIDE_W+30:0]    at_tag;
    logic [30:0]           at_sin;
    side_t                 at_side;
    logic [47:0]           ang1, ang2;
    logic                  ang_valid_reg;
    logic [30:0]           ang_a1_reg, ang_a2_reg;
    logic                  ang_lin_reg;
    logic [30:0]           ang_sin_reg;
    side_t                 ang_side_reg;
    logic                  sn_valid;
    logic [1:0][30:0]      sn_y;
    logic [SIDE_W+31:0]    sn_tag;
    logic                  dv_valid;
    logic [1:0][31:0]      dv_q;
    logic [SIDE_W:0]       dv_tag;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_side.p[i] = s_tdata[16*i +: 16];
            in_side.q[i] = {s_tdata[64+16*i+15], s_tdata[64+16*i +: 16]};
        end
        in_side.t = s_tdata[144:128];
    end

    qslerp_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_side   (in_side),
        .out_valid (dot_valid),
        .out_dot   (dot_val),
        .out_v     (dot_v),
        .out_side  (dot_side)
    );

    qslerp_isqrt #(.TAG_W(SIDE_W + 31)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dot_valid),
        .in_v      (dot_v),
        .in_tag    ({dot_val, dot_side}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    qslerp_cordic #(.VECTORING(1'b1), .LANES(1), .TAG_W(SIDE_W + 31)) u_atan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .x_i       (34'(sq_tag[SIDE_W +: 31])),
        .y_i       (34'(sq_root)),
        .z_i       (32'd0),
        .in_tag    ({sq_root, sq_tag[SIDE_W-1:0]}),
        .out_valid (at_valid),
        .y_o       (),
        .z_o       (at_theta),
        .out_tag   (at_tag)
    );

    assign at_sin  = at_tag[SIDE_W +: 31];
    assign at_side = side_t'(at_tag[SIDE_W-1:0]);
    assign ang1    = 48'(T_ONE - at_side.t) * 48'(at_theta[0]);
    assign ang2    = 48'(at_side.t) * 48'(at_theta[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_valid_reg <= 1'b0;
        end else if (en) begin
            ang_valid_reg <= at_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_a1_reg   <= ang1[46:16];
            ang_a2_reg   <= ang2[46:16];
            ang_lin_reg  <= !((at_theta[0] > THETA_MIN) && (at_sin != 31'd0));
            ang_sin_reg  <= at_sin;
            ang_side_reg <= at_side;
        end
    end

    qslerp_cordic #(.VECTORING(1'b0), .LANES(2), .TAG_W(SIDE_W + 32)) u_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ang_valid_reg),
        .x_i       ({INV_GAIN, INV_GAIN}),
        .y_i       ({34'd0, 34'd0}),
        .z_i       ({32'(ang_a2_reg), 32'(ang_a1_reg)}),
        .in_tag    ({ang_lin_reg, ang_sin_reg, ang_side_reg}),
        .out_valid (sn_valid),
        .y_o       (sn_y),
        .z_o       (),
        .out_tag   (sn_tag)
    );

    qslerp_div #(.LANES(2), .TAG_W(SIDE_W + 1)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sn_valid),
        .num_i     (sn_y),
        .den_i     (sn_tag[SIDE_W +: 31]),
        .in_tag    ({sn_tag[SIDE_W+31], sn_tag[SIDE_W-1:0]}),
        .out_valid (dv_valid),
        .q_o       (dv_q),
        .out_tag   (dv_tag)
    );

    qslerp_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (dv_valid),
        .in_lin     (dv_tag[SIDE_W]),
        .in_m1      (dv_q[0]),
        .in_m2      (dv_q[1]),
        .in_side    (side_t'(dv_tag[SIDE_W-1:0])),
        .out_valid  (m_tvalid),
        .out_result (m_tdata)
    );

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(ang_valid_reg) && $stable(ang_a1_reg) && $stable(ang_a2_reg))
        else $error("angle stage changed during a stall");

    a_angle_split: assert property (@(posedge aclk) disable iff (!aresetn)
        ang_valid_reg |-> (32'(ang_a1_reg) + 32'(ang_a2_reg) <= 32'(HALF_PI_Q30)))
        else $error("partial angles exceed the clamped theta range");

endmodule
